[rtl/ps2mpd_pkg.sv]
// ----------------------------------------------------------------------------
// ps2mpd_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mpd_pkg;

    // Reply bytes that answer a host command
    localparam logic [7:0] ACK_BYTE    = 8'hFA;
    localparam logic [7:0] RESEND_BYTE = 8'hFE;

    // Bit positions in the flags byte
    localparam int FLAG_SYNC_BIT  = 3;
    localparam int FLAG_XSIGN_BIT = 4;
    localparam int FLAG_YSIGN_BIT = 5;

    localparam int NUM_BUTTONS = 3;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Output bus widths
    localparam int M_TDATA_W = 24;

    // Byte position within a three-byte packet
    typedef enum logic [1:0] {
        PH_FLAGS,
        PH_DX,
        PH_DY
    } phase_t;

    typedef enum logic {
        EV_MOVE   = 1'b0,
        EV_BUTTON = 1'b1
    } event_kind_t;

    typedef enum logic [1:0] {
        BTN_LEFT,
        BTN_RIGHT,
        BTN_MIDDLE
    } button_id_t;

    // One completed packet, ready to be turned into events
    typedef struct packed {
        logic                   has_move;
        logic [8:0]             dx;
        logic [9:0]             dy;
        logic [NUM_BUTTONS-1:0] changed;
        logic [NUM_BUTTONS-1:0] buttons;
    } job_t;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

`default_nettype wire

[rtl/ps2mpd_front.sv]
// ----------------------------------------------------------------------------
// ps2mpd_front
// Accepts mouse bytes, drops command replies and bad flags bytes, assembles
// three-byte packets and pushes one job per non-quiet packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mpd_front
    import ps2mpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tuser,   // [0] reply_awaited
    input  wire logic       q_full,
    output logic            push,
    output job_t            push_job
);

    phase_t                 phase_reg, phase_next;
    logic [7:0]             held_flags_reg, held_flags_next;
    logic [7:0]             held_dx_reg, held_dx_next;
    logic [NUM_BUTTONS-1:0] button_reg, button_next;

    logic       s_fire;
    logic       is_reply;
    logic       take;
    logic       capture_flags;
    logic       capture_dx;
    logic       complete;
    logic [8:0] dx9;
    logic [8:0] dy9;
    logic [NUM_BUTTONS-1:0] changed;

    assign s_tready = !q_full;
    assign s_fire   = s_tvalid && s_tready;

    // Reply bytes are swallowed only while a command is pending
    assign is_reply = s_tuser && (s_tdata inside {ACK_BYTE, RESEND_BYTE});
    assign take     = s_fire && !is_reply;

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_DX: begin
                if (take) phase_next = PH_DY;
            end
            PH_DY: begin
                if (take) phase_next = PH_FLAGS;
            end
            default: begin
                if (take) phase_next = s_tdata[FLAG_SYNC_BIT] ? PH_DX : PH_FLAGS;
            end
        endcase
    end

    // Phase-dependent strobes
    always_comb begin
        capture_flags = 1'b0;
        capture_dx    = 1'b0;
        complete      = 1'b0;
        case (phase_reg)
            PH_DX:   capture_dx    = take;
            PH_DY:   complete      = take;
            default: capture_flags = take && s_tdata[FLAG_SYNC_BIT];
        endcase
    end

    // Packet decode
    assign dx9     = {held_flags_reg[FLAG_XSIGN_BIT], held_dx_reg};
    assign dy9     = {held_flags_reg[FLAG_YSIGN_BIT], s_tdata};
    assign changed = held_flags_reg[NUM_BUTTONS-1:0] ^ button_reg;

    always_comb begin
        push_job.has_move = (dx9 != 9'd0) || (dy9 != 9'd0);
        push_job.dx       = dx9;
        push_job.dy       = 10'd0 - {dy9[8], dy9};
        push_job.changed  = changed;
        push_job.buttons  = held_flags_reg[NUM_BUTTONS-1:0];
        push = complete && (push_job.has_move || (changed != '0));
    end

    // Held bytes and button state
    always_comb begin
        held_flags_next = capture_flags ? s_tdata : held_flags_reg;
        held_dx_next    = capture_dx ? s_tdata : held_dx_reg;
        button_next     = complete ? held_flags_reg[NUM_BUTTONS-1:0] : button_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_FLAGS;
            held_flags_reg <= '0;
            held_dx_reg    <= '0;
            button_reg     <= '0;
        end else begin
            phase_reg      <= phase_next;
            held_flags_reg <= held_flags_next;
            held_dx_reg    <= held_dx_next;
            button_reg     <= button_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ps2mpd_queue.sv]
// ----------------------------------------------------------------------------
// ps2mpd_queue
// Small job queue that decouples packet assembly from event emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mpd_queue
    import ps2mpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire job_t    push_job,
    input  wire logic    pop,
    output job_t         pop_job,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.valid = (count_reg != '0);
    assign pop_job      = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        status.full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.valid |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

[rtl/ps2mpd_back.sv]
// ----------------------------------------------------------------------------
// ps2mpd_back
// Takes jobs from the queue and emits the move event and the button change
// events, one per cycle while m_tready allows, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mpd_back
    import ps2mpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire queue_status_t q_status,
    input  wire job_t       pop_job,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [8:0] move_dx, [18:9] move_dy,
                                           // [20:19] button_id,
                                           // [21] button_pressed, [23:22] zero
    output logic            m_tuser,       // [0] event_kind
    output logic            m_tlast        // last_of_packet
);

    // Job being worked on; pend bit 0 is the move, bits 1..3 the buttons
    logic                     job_valid_reg, job_valid_next;
    job_t                     job_reg, job_next;
    logic [NUM_BUTTONS:0]     pend_reg, pend_next;

    // Output stage
    logic                     m_tvalid_reg, m_tvalid_next;
    event_kind_t              kind_reg, kind_next;
    logic [8:0]               dx_reg, dx_next;
    logic [9:0]               dy_reg, dy_next;
    button_id_t               id_reg, id_next;
    logic                     pressed_reg, pressed_next;
    logic                     last_reg, last_next;

    logic                     load;
    logic                     adv;
    event_kind_t              ev_kind;
    logic [8:0]               ev_dx;
    logic [9:0]               ev_dy;
    button_id_t               ev_id;
    logic                     ev_pressed;
    logic [NUM_BUTTONS:0]     pend_after;
    logic                     ev_last;

    assign load = !m_tvalid_reg || m_tready;
    assign adv  = job_valid_reg && load;
    assign pop  = q_status.valid && (!job_valid_reg || (adv && ev_last));

    // Pick the lowest pending event
    always_comb begin
        ev_kind    = EV_BUTTON;
        ev_dx      = '0;
        ev_dy      = '0;
        ev_id      = BTN_LEFT;
        ev_pressed = 1'b0;
        pend_after = pend_reg;
        if (pend_reg[0]) begin
            ev_kind       = EV_MOVE;
            ev_dx         = job_reg.dx;
            ev_dy         = job_reg.dy;
            pend_after[0] = 1'b0;
        end else if (pend_reg[1]) begin
            ev_id         = BTN_LEFT;
            ev_pressed    = job_reg.buttons[0];
            pend_after[1] = 1'b0;
        end else if (pend_reg[2]) begin
            ev_id         = BTN_RIGHT;
            ev_pressed    = job_reg.buttons[1];
            pend_after[2] = 1'b0;
        end else begin
            ev_id         = BTN_MIDDLE;
            ev_pressed    = job_reg.buttons[2];
            pend_after[3] = 1'b0;
        end
        ev_last = (pend_after == '0);
    end

    // Job register
    always_comb begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        pend_next      = pend_reg;
        if (pop) begin
            job_valid_next = 1'b1;
            job_next       = pop_job;
            pend_next      = {pop_job.changed, pop_job.has_move};
        end else if (adv) begin
            pend_next = pend_after;
            if (ev_last) job_valid_next = 1'b0;
        end
    end

    // Output register
    always_comb begin
        m_tvalid_next = load ? job_valid_reg : m_tvalid_reg;
        kind_next     = kind_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        id_next       = id_reg;
        pressed_next  = pressed_reg;
        last_next     = last_reg;
        if (adv) begin
            kind_next    = ev_kind;
            dx_next      = ev_dx;
            dy_next      = ev_dy;
            id_next      = ev_id;
            pressed_next = ev_pressed;
            last_next    = ev_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            pend_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg     <= job_next;
        kind_reg    <= kind_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        id_reg      <= id_next;
        pressed_reg <= pressed_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, pressed_reg, id_reg, dy_reg, dx_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_job_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> (pend_reg != '0))
        else $error("active job with nothing pending");

    a_button_no_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && kind_reg == EV_BUTTON) |-> (dx_reg == '0 && dy_reg == '0))
        else $error("button event carries motion");

    a_move_not_after_button: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && ev_kind == EV_MOVE) |-> (pend_reg[NUM_BUTTONS:1] == job_reg.changed))
        else $error("move event emitted after a button event");
`endif

endmodule

`default_nettype wire

[rtl/ps2_mouse_packet_decoder.sv]
// Result path: a packet's third byte reaches m_tvalid through the job queue, the job register
// and the output register; other bytes, and quiet packets, produce no result.
// Throughput: one byte per cycle while the job queue has room; the back end emits one
// event per cycle while m_tready allows, up to 4 per packet, so a run of 4-event packets
// holds the input back once the queue is full.
// Reset: synchronous active-low aresetn clears phase, buttons, queue and output.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Decodes three-byte PS/2 mouse packets into move and button change events.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_decoder
    import ps2mpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] data_byte
    input  wire logic                 s_tuser,   // [0] reply_awaited
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [8:0] move_dx, [18:9] move_dy,
                                                 // [20:19] button_id,
                                                 // [21] button_pressed, [23:22] zero
    output logic                      m_tuser,   // [0] event_kind
    output logic                      m_tlast    // last_of_packet
);

    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          pop_job;
    queue_status_t q_status;

    ps2mpd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_status.full),
        .push     (push),
        .push_job (push_job)
    );

    ps2mpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    ps2mpd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[bench/tb_ps2_mouse_packet_decoder.sv]
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_decoder
// Self-checking bench for the PS/2 mouse packet decoder. A directed table
// covers reply bytes, corrupt flags bytes, quiet packets and delta extremes.
// Random traffic follows, mostly whole packets with injected ACK/RESEND
// replies, stray bytes and cut-off packets. A software decoder predicts every
// move and button event, and each result transaction is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_ps2_mouse_packet_decoder
    import ps2mpd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 1000;  // cycles with no transaction on either side
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 206;   // random bytes, on top of the directed rows
    localparam int DIR_ROWS     = 24;

    // One decoded event as it leaves the block
    typedef struct packed {
        event_kind_t kind;
        logic [8:0]  dx;
        logic [9:0]  dy;
        button_id_t  id;
        logic        pressed;
        logic        last;
    } mouse_event_t;

    // Directed stimulus row; typed rows carry their expected event inline
    typedef struct packed {
        logic [7:0]   data;
        logic         awaited;
        logic         typed;
        logic         has_ev;
        mouse_event_t ev;
    } stim_row_t;

    localparam mouse_event_t NO_EVENT = mouse_event_t'(0);
    localparam mouse_event_t LEFT_DOWN_LAST = '{
        kind: EV_BUTTON, dx: 9'd0, dy: 10'd0, id: BTN_LEFT, pressed: 1'b1, last: 1'b1
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    ps2_mouse_packet_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Decoder shadow state
    phase_t       pkt_phase = PH_FLAGS;
    logic [7:0]   pkt_flags = 8'h00;
    logic [7:0]   pkt_dx    = 8'h00;
    logic [2:0]   btn_state = 3'b000;
    mouse_event_t packet_events[$];
    mouse_event_t expected_events[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int bytes_sent    = 0;
    int decoded_items = 0;
    int events_seen   = 0;
    int moves_seen    = 0;
    int buttons_seen  = 0;
    int stall_cycles  = 0;

    stim_row_t dir_tab [DIR_ROWS];

    // Decode one byte into packet_events; returns 1 when the byte is ignored
    function automatic bit decode_byte(input logic [7:0] b, input logic aw);
        logic [8:0]   dx9;
        logic [9:0]   dy10;
        mouse_event_t ev;
        bit           ignored;
        ignored = 1'b0;
        packet_events.delete();
        if (aw && (b == ACK_BYTE || b == RESEND_BYTE)) begin
            ignored = 1'b1;
        end else begin
            case (pkt_phase)
                PH_DX: begin
                    pkt_dx    = b;
                    pkt_phase = PH_DY;
                end
                PH_DY: begin
                    dx9  = {pkt_flags[FLAG_XSIGN_BIT], pkt_dx};
                    dy10 = {{2{pkt_flags[FLAG_YSIGN_BIT]}}, b};
                    if (dx9 != 9'd0 || dy10 != 10'd0) begin
                        ev = '{kind: EV_MOVE, dx: dx9, dy: 10'd0 - dy10, id: BTN_LEFT,
                               pressed: 1'b0, last: 1'b0};
                        packet_events.push_back(ev);
                    end
                    for (int i = 0; i < NUM_BUTTONS; i++) begin
                        if (pkt_flags[i] != btn_state[i]) begin
                            ev = '{kind: EV_BUTTON, dx: 9'd0, dy: 10'd0,
                                   id: button_id_t'(i), pressed: pkt_flags[i], last: 1'b0};
                            packet_events.push_back(ev);
                        end
                    end
                    if (packet_events.size() > 0)
                        packet_events[packet_events.size() - 1].last = 1'b1;
                    btn_state = pkt_flags[2:0];
                    pkt_phase = PH_FLAGS;
                end
                default: begin
                    // flags byte: sync bit must be set, otherwise dropped
                    if (b[FLAG_SYNC_BIT]) begin
                        pkt_flags = b;
                        pkt_phase = PH_DX;
                    end else begin
                        pkt_phase = PH_FLAGS;
                        ignored   = 1'b1;
                    end
                end
            endcase
        end
        return ignored;
    endfunction

    // Drive one byte; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic aw, input logic typed,
                             input logic has_ev, input mouse_event_t ev);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= aw;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!decode_byte(b, aw))
            decoded_items++;
        if (typed) begin
            if (has_ev)
                expected_events.push_back(ev);
        end else begin
            foreach (packet_events[i])
                expected_events.push_back(packet_events[i]);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Hold the input side until every predicted event has come out
    task automatic drain_events;
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_events.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [23:0] want_v,
                               input logic [23:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Result side backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker
    always @(posedge aclk) begin
        mouse_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            events_seen++;
            if (m_tuser == EV_MOVE) moves_seen++;
            else buttons_seen++;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s 0x%0h tuser %0b tlast %0b",
                         $time, "actual tdata", m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", 24'(want.kind), 24'(m_tuser));
                check_field("move_dx", 24'(want.dx), 24'(m_tdata[8:0]));
                check_field("move_dy", 24'(want.dy), 24'(m_tdata[18:9]));
                check_field("button_id", 24'(want.id), 24'(m_tdata[20:19]));
                check_field("button_pressed", 24'(want.pressed), 24'(m_tdata[21]));
                check_field("tdata pad", 24'd0, 24'(m_tdata[23:22]));
                check_field("last_of_packet", 24'(want.last), 24'(m_tlast));
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d events outstanding",
                     $time, stall_cycles, expected_events.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int           send_pct [3];
        int           recv_pct [3];
        int           target;
        int           roll;
        int           cut;
        logic [31:0]  rnd;
        logic [7:0]   pkt [3];
        logic         aw;

        send_pct = '{19, 49, 0};
        recv_pct = '{49, 19, 0};

        dir_tab = '{
            // replies while a command is pending: consumed
            '{8'hFA, 1'b1, 1'b1, 1'b0, NO_EVENT},
            '{8'hFE, 1'b1, 1'b1, 1'b0, NO_EVENT},
            // corrupt flags bytes: dropped
            '{8'h00, 1'b0, 1'b1, 1'b0, NO_EVENT},
            '{8'hF7, 1'b0, 1'b1, 1'b0, NO_EVENT},
            // quiet packet
            '{8'h08, 1'b0, 1'b1, 1'b0, NO_EVENT},
            '{8'h00, 1'b0, 1'b1, 1'b0, NO_EVENT},
            '{8'h00, 1'b0, 1'b1, 1'b0, NO_EVENT},
            // left press only
            '{8'h09, 1'b0, 1'b1, 1'b0, NO_EVENT},
            '{8'h00, 1'b0, 1'b1, 1'b0, NO_EVENT},
            '{8'h00, 1'b0, 1'b1, 1'b1, LEFT_DOWN_LAST},
            // most negative deltas, all flags set
            '{8'hFF, 1'b0, 1'b0, 1'b0, NO_EVENT},
            '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
            '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
            // reply codes as packet bytes with no command pending
            '{8'hFA, 1'b0, 1'b0, 1'b0, NO_EVENT},
            '{8'hFE, 1'b0, 1'b0, 1'b0, NO_EVENT},
            '{8'hFF, 1'b1, 1'b0, 1'b0, NO_EVENT},
            // replies interleaved inside a packet
            '{8'h38, 1'b0, 1'b0, 1'b0, NO_EVENT},
            '{8'hFA, 1'b1, 1'b0, 1'b0, NO_EVENT},
            '{8'hFF, 1'b0, 1'b0, 1'b0, NO_EVENT},
            '{8'hFE, 1'b1, 1'b0, 1'b0, NO_EVENT},
            '{8'h7F, 1'b0, 1'b0, 1'b0, NO_EVENT},
            // positive deltas, all buttons released
            '{8'h08, 1'b0, 1'b0, 1'b0, NO_EVENT},
            '{8'h7F, 1'b0, 1'b0, 1'b0, NO_EVENT},
            '{8'h80, 1'b0, 1'b0, 1'b0, NO_EVENT}
        };

        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table
        foreach (dir_tab[i])
            send_byte(dir_tab[i].data, dir_tab[i].awaited, dir_tab[i].typed,
                      dir_tab[i].has_ev, dir_tab[i].ev);
        drain_events();

        // Random traffic in three idle mixes, drained between mixes
        target = bytes_sent;
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = send_pct[p];
            recv_idle_pct = recv_pct[p];
            target += RANDOM_ITEMS / 3 + ((p == 2) ? RANDOM_ITEMS % 3 : 0);
            while (bytes_sent < target) begin
                roll = $urandom_range(0, 99);
                rnd  = $urandom;
                if (roll < 87) begin
                    // whole packet, or a cut-off one in about one case of seven
                    pkt[0] = rnd[7:0] | 8'h08;
                    pkt[1] = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom);
                    pkt[2] = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom);
                    cut = (roll >= 75) ? $urandom_range(1, 2) : 3;
                    for (int j = 0; j < cut; j++) begin
                        if ($urandom_range(0, 11) == 0)
                            send_byte($urandom_range(0, 1) ? ACK_BYTE : RESEND_BYTE, 1'b1,
                                      1'b0, 1'b0, NO_EVENT);
                        aw = (pkt[j] == ACK_BYTE || pkt[j] == RESEND_BYTE) ? 1'b0
                             : ($urandom_range(0, 3) == 0);
                        send_byte(pkt[j], aw, 1'b0, 1'b0, NO_EVENT);
                    end
                end else begin
                    // stray byte with either flag value
                    send_byte(rnd[7:0], rnd[8], 1'b0, 1'b0, NO_EVENT);
                end
            end
            drain_events();
        end

        // Let the block settle and catch any extra results
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Sent %0d bytes (%0d decoded, rest consumed replies or dropped flags)",
                 bytes_sent, decoded_items);
        $display("Checked %0d events: %0d moves, %0d button changes, over three idle mixes",
                 events_seen, moves_seen, buttons_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
